// ----- src/tdgr_pkg.sv -----
// ----------------------------------------------------------------------------
// tdgr_pkg
// Shared types and constants for the tap-dance gesture resolver.
// ----------------------------------------------------------------------------
package tdgr_pkg;

    // Field widths of the request, result and configuration channels.
    localparam int KEY_W     = 16;
    localparam int MS_W      = 16;
    localparam int TARGET_W  = 4;
    localparam int KIND_W    = 3;
    localparam int CFG_IDX_W = 8;
    localparam int CFG_DAT_W = 16;

    // Default saturation limit of the press counter.
    localparam int PRESS_COUNT_MAX_DEF = 31;

    // Configuration reset values.
    localparam logic [KEY_W-1:0]    TRIGGER_KEY_RST    = 16'd0;
    localparam logic [TARGET_W-1:0] TARGET_PRESSES_RST = 4'd2;
    localparam logic                HOLD_MODE_RST      = 1'b0;
    localparam logic [MS_W-1:0]     TAP_TIMEOUT_RST    = 16'd200;

    // Query kinds carried by each request.
    typedef enum logic [KIND_W-1:0] {
        KIND_INITIAL     = 3'd0,
        KIND_PARTIAL     = 3'd1,
        KIND_COMPLETE    = 3'd2,
        KIND_ACT_INITIAL = 3'd3,
        KIND_ACT_REPLAY  = 3'd4,
        KIND_ACTIVE      = 3'd5
    } t_kind;

    // Configuration register indexes.
    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_TRIGGER_KEY    = 8'd0,
        CFG_TARGET_PRESSES = 8'd1,
        CFG_HOLD_MODE      = 8'd2,
        CFG_TAP_TIMEOUT    = 8'd3
    } t_cfg_idx;

endpackage

// ----- src/tdgr_in_if.sv -----
// ----------------------------------------------------------------------------
// tdgr_in_if
// Request channel: one gesture query with its key event.
// ----------------------------------------------------------------------------
interface tdgr_in_if;
    logic                            valid;
    logic                            ready;
    logic [tdgr_pkg::KIND_W-1:0]     kind;
    logic                            is_key_event;
    logic [tdgr_pkg::KEY_W-1:0]      event_key;
    logic                            pressed;
    logic [tdgr_pkg::MS_W-1:0]       ms_left;

    modport source (output valid, kind, is_key_event, event_key, pressed, ms_left,
                    input ready);
    modport sink   (input valid, kind, is_key_event, event_key, pressed, ms_left,
                    output ready);
endinterface

// ----- src/tdgr_out_if.sv -----
// ----------------------------------------------------------------------------
// tdgr_out_if
// Result channel: timeout and outcome of one query.
// ----------------------------------------------------------------------------
interface tdgr_out_if;
    logic                        valid;
    logic                        ready;
    logic [tdgr_pkg::MS_W-1:0]   timeout_ms;
    logic                        timeout_never;
    logic                        outcome;

    modport source (output valid, timeout_ms, timeout_never, outcome, input ready);
    modport sink   (input valid, timeout_ms, timeout_never, outcome, output ready);
endinterface

// ----- src/tdgr_cfg_if.sv -----
// ----------------------------------------------------------------------------
// tdgr_cfg_if
// Configuration write channel: register index and write data.
// ----------------------------------------------------------------------------
interface tdgr_cfg_if;
    logic                             valid;
    logic                             ready;
    logic [tdgr_pkg::CFG_IDX_W-1:0]   index;
    logic [tdgr_pkg::CFG_DAT_W-1:0]   data;

    modport source (output valid, index, data, input ready);
    modport sink   (input valid, index, data, output ready);
endinterface

// ----- src/tap_dance_gesture_resolver_core.sv -----
// ----------------------------------------------------------------------------
// tap_dance_gesture_resolver_core
// Matches one tap-dance gesture and answers timeout and outcome per query.
// ----------------------------------------------------------------------------
// Each query request is decoded combinationally: the press counter and
// key-down flag update on acceptance, and the answer is loaded into the
// result register at the same edge. A new request is taken every cycle as
// long as the result register is empty or being drained, so throughput is
// one request per clock. Configuration writes are accepted every cycle and
// should be issued only while no request is in flight.
// ----------------------------------------------------------------------------
module tap_dance_gesture_resolver_core #(
    parameter int PRESS_COUNT_MAX = tdgr_pkg::PRESS_COUNT_MAX_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    tdgr_in_if.sink     i_in,
    tdgr_out_if.source  o_out,
    tdgr_cfg_if.sink    i_cfg
);

    localparam int CNT_W = $clog2(PRESS_COUNT_MAX + 1);
    localparam logic [CNT_W-1:0] CNT_MAX = CNT_W'(PRESS_COUNT_MAX);

    // Configuration registers.
    logic [tdgr_pkg::KEY_W-1:0]    r_trigger_key;
    logic [tdgr_pkg::TARGET_W-1:0] r_target;
    logic                          r_hold_mode;
    logic [tdgr_pkg::MS_W-1:0]     r_tap_timeout;

    // Gesture state.
    logic [CNT_W-1:0] r_count, n_count;
    logic             r_down,  n_down;

    // Result register.
    logic                      r_out_valid;
    logic [tdgr_pkg::MS_W-1:0] r_timeout, n_timeout;
    logic                      r_never,   n_never;
    logic                      r_outcome, n_outcome;

    logic             in_accept;
    logic             trig;
    logic [CNT_W-1:0] target_ext;
    logic [CNT_W-1:0] base_count;
    logic             base_down;
    logic             resolved;

    // Saturating increment of the press counter.
    function automatic logic [CNT_W-1:0] bump(input logic [CNT_W-1:0] c);
        bump = (c < CNT_MAX) ? c + CNT_W'(1) : c;
    endfunction

    // The gesture activates when the count hits the target with the key held
    // (hold variant) or released (tap variant).
    function automatic logic activate(input logic [CNT_W-1:0] c, input logic d,
                                      input logic [CNT_W-1:0] tgt, input logic hm);
        activate = (c == tgt) && (hm ? d : !d);
    endfunction

    assign i_cfg.ready = 1'b1;
    assign i_in.ready  = !r_out_valid || o_out.ready;
    assign in_accept   = i_in.valid && i_in.ready;

    assign o_out.valid         = r_out_valid;
    assign o_out.timeout_ms    = r_timeout;
    assign o_out.timeout_never = r_never;
    assign o_out.outcome       = r_outcome;

    // Configuration writes; indexes past the list are ignored.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_trigger_key <= tdgr_pkg::TRIGGER_KEY_RST;
            r_target      <= tdgr_pkg::TARGET_PRESSES_RST;
            r_hold_mode   <= tdgr_pkg::HOLD_MODE_RST;
            r_tap_timeout <= tdgr_pkg::TAP_TIMEOUT_RST;
        end else if (i_cfg.valid) begin
            case (tdgr_pkg::t_cfg_idx'(i_cfg.index))
                tdgr_pkg::CFG_TRIGGER_KEY: begin
                    r_trigger_key <= i_cfg.data[tdgr_pkg::KEY_W-1:0];
                end
                tdgr_pkg::CFG_TARGET_PRESSES: begin
                    r_target <= i_cfg.data[tdgr_pkg::TARGET_W-1:0];
                end
                tdgr_pkg::CFG_HOLD_MODE: begin
                    r_hold_mode <= i_cfg.data[0];
                end
                tdgr_pkg::CFG_TAP_TIMEOUT: begin
                    r_tap_timeout <= i_cfg.data[tdgr_pkg::MS_W-1:0];
                end
                default: begin
                end
            endcase
        end
    end

    assign trig       = i_in.is_key_event && (i_in.event_key == r_trigger_key);
    assign target_ext = CNT_W'(r_target);

    // Query decode: next gesture state and the answer for this request.
    always_comb begin
        n_count    = r_count;
        n_down     = r_down;
        n_timeout  = '0;
        n_never    = 1'b0;
        n_outcome  = 1'b0;
        base_count = r_count;
        base_down  = r_down;
        resolved   = 1'b0;
        case (tdgr_pkg::t_kind'(i_in.kind))
            tdgr_pkg::KIND_INITIAL: begin
                if (trig && i_in.pressed) begin
                    n_count   = CNT_W'(1);
                    n_down    = 1'b1;
                    n_timeout = r_tap_timeout;
                    n_outcome = activate(CNT_W'(1), 1'b1, target_ext, r_hold_mode);
                end
            end
            tdgr_pkg::KIND_PARTIAL, tdgr_pkg::KIND_COMPLETE: begin
                if (trig) begin
                    n_count   = i_in.pressed ? bump(r_count) : r_count;
                    n_down    = i_in.pressed;
                    resolved  = (n_count > target_ext) ||
                                ((n_count == target_ext) && !n_down);
                    n_timeout = resolved ? '0 : r_tap_timeout;
                    n_outcome = activate(n_count, n_down, target_ext, r_hold_mode);
                end else if (i_in.ms_left == '0) begin
                    // Default hold rule: resolve once no time remains.
                    n_outcome = r_hold_mode;
                end else begin
                    n_timeout = i_in.ms_left;
                    n_outcome = activate(r_count, r_down, target_ext, r_hold_mode);
                end
            end
            tdgr_pkg::KIND_ACT_INITIAL, tdgr_pkg::KIND_ACT_REPLAY: begin
                // A fresh activation starts counting from zero.
                if (tdgr_pkg::t_kind'(i_in.kind) == tdgr_pkg::KIND_ACT_INITIAL) begin
                    base_count = '0;
                    base_down  = 1'b0;
                end
                n_count = base_count;
                n_down  = base_down;
                if (trig) begin
                    n_count   = i_in.pressed ? bump(base_count) : base_count;
                    n_down    = i_in.pressed;
                    n_outcome = 1'b1;
                    n_never   = r_hold_mode ||
                                !(!i_in.pressed && (n_count >= target_ext));
                end else begin
                    n_never = 1'b1;
                end
            end
            tdgr_pkg::KIND_ACTIVE: begin
                if (r_hold_mode) begin
                    if (trig && !i_in.pressed) begin
                        n_down = 1'b0;
                    end else begin
                        n_never = 1'b1;
                    end
                end
            end
            default: begin
            end
        endcase
    end

    // Gesture state updates on each accepted request.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
            r_down  <= 1'b0;
        end else if (in_accept) begin
            r_count <= n_count;
            r_down  <= n_down;
        end
    end

    // Result register: loaded on accept, emptied when the sink takes it.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (in_accept) begin
            r_out_valid <= 1'b1;
        end else if (o_out.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_accept) begin
            r_timeout <= n_timeout;
            r_never   <= n_never;
            r_outcome <= n_outcome;
        end
    end

`ifndef ASSERT_OFF
    // The press counter never passes its saturation limit.
    a_count_sat: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CNT_MAX)
        else $error("press count above limit");

    // A held trigger key always implies at least one counted press.
    a_down_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_down |-> (r_count != '0))
        else $error("key down with zero press count");

    // A result that waits indefinitely carries a zero timeout.
    a_never_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_never) |-> (r_timeout == '0))
        else $error("never result with nonzero timeout");

    // Every accepted request shows a result in the next cycle.
    a_accept_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_accept |=> r_out_valid)
        else $error("accepted request produced no result");
`endif

endmodule

// ----- bench/tb.sv -----
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the tap-dance gesture resolver core.
// ----------------------------------------------------------------------------
// A short table of hand-picked requests runs first against reset settings.
// Rows whose answer is obvious carry it typed in; the others go through the
// bench's own gesture tracker. Several random phases follow, each with fresh
// register settings. Most requests in those phases form realistic tap
// sequences with stray keys mixed in, and the rest are noise. Both sides of
// the request and result channels idle at random. One phase holds the result
// side off for a long stretch, and another runs with no idling at all.
// ----------------------------------------------------------------------------
module tb;

    localparam int KIND_W    = tdgr_pkg::KIND_W;
    localparam int KEY_W     = tdgr_pkg::KEY_W;
    localparam int MS_W      = tdgr_pkg::MS_W;
    localparam int TARGET_W  = tdgr_pkg::TARGET_W;
    localparam int CFG_DAT_W = tdgr_pkg::CFG_DAT_W;

    localparam int PRESS_MAX       = tdgr_pkg::PRESS_COUNT_MAX_DEF;
    localparam int IDLE_PCT        = 16;
    localparam int PHASES          = 8;
    localparam int PHASE_REQUESTS  = 125;
    localparam int CALM_PHASE      = 3;
    localparam int PRESSURE_PHASE  = 4;
    localparam int PRESSURE_CYCLES = 300;
    localparam int DRAIN_CYCLES    = 8;
    localparam int RESET_CYCLES    = 12;
    localparam int CYCLE_LIMIT     = 400000;
    localparam int REPORT_MAX      = 10;
    localparam int DIRECTED_ROWS   = 18;

    // Kinds outside the defined set; the block must answer them with nothing.
    localparam logic [KIND_W-1:0] KIND_SPARE_A = 3'd6;
    localparam logic [KIND_W-1:0] KIND_SPARE_B = 3'd7;

    localparam logic [KEY_W-1:0] STRAY_KEY = 16'h0005;
    localparam logic [KEY_W-1:0] TRIG_RST  = tdgr_pkg::TRIGGER_KEY_RST;
    localparam logic [MS_W-1:0]  TAP_RST   = tdgr_pkg::TAP_TIMEOUT_RST;

    typedef struct packed {
        logic [KIND_W-1:0] kind;
        logic              is_key;
        logic [KEY_W-1:0]  key;
        logic              pressed;
        logic [MS_W-1:0]   remaining;
    } t_query;

    typedef struct packed {
        logic [MS_W-1:0] timeout;
        logic            never;
        logic            outcome;
    } t_answer;

    typedef struct packed {
        t_query  q;
        logic    fixed;
        t_answer want;
    } t_row;

    logic i_clk;
    logic i_rst_n;

    tdgr_in_if  in_if ();
    tdgr_out_if out_if ();
    tdgr_cfg_if cfg_if ();

    tap_dance_gesture_resolver_core uut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (in_if),
        .o_out   (out_if),
        .i_cfg   (cfg_if)
    );

    // Gesture tracker: register copies and the counted state.
    logic [KEY_W-1:0]    cfg_trigger;
    logic [TARGET_W-1:0] cfg_target;
    logic                cfg_hold;
    logic [MS_W-1:0]     cfg_tap;
    int                  presses;
    logic                key_held;

    t_answer answers_due[$];
    t_row    directed_rows [DIRECTED_ROWS];
    int      errors;
    int      requests_sent;
    int      phase_no;

    // Clock with a period of two time units.
    initial begin
        i_clk = 1'b0;
        forever #1 i_clk = ~i_clk;
    end

    // The gesture matches at the target count, held or released per mode.
    function automatic logic gesture_fires();
        if (presses != cfg_target) begin
            return 1'b0;
        end
        return cfg_hold ? key_held : !key_held;
    endfunction

    // A trigger press counts up to the ceiling; any trigger event sets the flag to its pressed state.
    function automatic void take_trigger(logic pressed);
        if (pressed && presses < PRESS_MAX) begin
            presses++;
        end
        key_held = pressed;
    endfunction

    // Works out the answer to one request and advances the tracked state.
    function automatic t_answer resolve_gesture(t_query q);
        t_answer a;
        logic    trig;
        a    = '0;
        trig = q.is_key && q.key == cfg_trigger;
        case (q.kind)
            tdgr_pkg::KIND_INITIAL: begin
                if (trig && q.pressed) begin
                    presses   = 1;
                    key_held  = 1'b1;
                    a.timeout = cfg_tap;
                    a.outcome = gesture_fires();
                end
            end
            tdgr_pkg::KIND_PARTIAL, tdgr_pkg::KIND_COMPLETE: begin
                if (trig) begin
                    take_trigger(q.pressed);
                    // Past the target, or at it with the key up, resolves now.
                    if (!(presses > cfg_target || (presses == cfg_target && !key_held))) begin
                        a.timeout = cfg_tap;
                    end
                    a.outcome = gesture_fires();
                end else if (q.remaining == '0) begin
                    a.outcome = cfg_hold;
                end else begin
                    a.timeout = q.remaining;
                    a.outcome = gesture_fires();
                end
            end
            tdgr_pkg::KIND_ACT_INITIAL, tdgr_pkg::KIND_ACT_REPLAY: begin
                if (q.kind == tdgr_pkg::KIND_ACT_INITIAL) begin
                    presses  = 0;
                    key_held = 1'b0;
                end
                a.never = 1'b1;
                if (trig) begin
                    take_trigger(q.pressed);
                    a.outcome = 1'b1;
                    if (!cfg_hold && !q.pressed && presses >= cfg_target) begin
                        a.never = 1'b0;
                    end
                end
            end
            tdgr_pkg::KIND_ACTIVE: begin
                if (cfg_hold) begin
                    if (trig && !q.pressed) begin
                        key_held = 1'b0;
                    end else begin
                        a.never = 1'b1;
                    end
                end
            end
            default: ;
        endcase
        return a;
    endfunction

    function automatic t_row dr(logic [KIND_W-1:0] kind, logic is_key, logic [KEY_W-1:0] key,
                                logic pressed, logic [MS_W-1:0] remaining, logic fixed,
                                logic [MS_W-1:0] timeout, logic never, logic outcome);
        t_row r;
        r.q    = '{kind, is_key, key, pressed, remaining};
        r.fixed = fixed;
        r.want = '{timeout, never, outcome};
        return r;
    endfunction

    function automatic t_query trigger_ev(logic [KIND_W-1:0] kind, logic pressed);
        t_query q;
        q.kind      = kind;
        q.is_key    = 1'b1;
        q.key       = cfg_trigger;
        q.pressed   = pressed;
        q.remaining = MS_W'($urandom_range(0, 65535));
        return q;
    endfunction

    // A stray event: another key, or a non-key event that may carry the trigger code.
    function automatic t_query other_ev(logic [KIND_W-1:0] kind);
        t_query q;
        q.kind    = kind;
        q.is_key  = ($urandom_range(0, 3) != 0);
        if (q.is_key) begin
            q.key = cfg_trigger ^ KEY_W'($urandom_range(1, 65535));
        end else begin
            q.key = ($urandom_range(0, 1) != 0) ? cfg_trigger : KEY_W'($urandom_range(0, 65535));
        end
        q.pressed   = 1'($urandom_range(0, 1));
        q.remaining = ($urandom_range(0, 4) == 0) ? '0 : MS_W'($urandom_range(0, 65535));
        return q;
    endfunction

    function automatic logic [KIND_W-1:0] recog_kind();
        return ($urandom_range(0, 1) != 0) ? tdgr_pkg::KIND_PARTIAL : tdgr_pkg::KIND_COMPLETE;
    endfunction

    // Offers one request, idling at random first outside the calm phase; valid stays high afterwards.
    task automatic send_query(t_query q, logic fixed, t_answer want);
        while (phase_no != CALM_PHASE && $urandom_range(99) < IDLE_PCT) begin
            in_if.valid <= 1'b0;
            @(posedge i_clk);
        end
        in_if.valid        <= 1'b1;
        in_if.kind         <= q.kind;
        in_if.is_key_event <= q.is_key;
        in_if.event_key    <= q.key;
        in_if.pressed      <= q.pressed;
        in_if.ms_left      <= q.remaining;
        @(posedge i_clk);
        while (!in_if.ready) begin
            @(posedge i_clk);
        end
        requests_sent++;
        if (fixed) begin
            void'(resolve_gesture(q));
            answers_due.push_back(want);
        end else begin
            answers_due.push_back(resolve_gesture(q));
        end
    endtask

    // Stops offering requests and lets every pending answer come back.
    task automatic drain_results();
        in_if.valid <= 1'b0;
        @(posedge i_clk);
        while (answers_due.size() != 0) begin
            @(posedge i_clk);
        end
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_reg(tdgr_pkg::t_cfg_idx idx, logic [CFG_DAT_W-1:0] data);
        cfg_if.valid <= 1'b1;
        cfg_if.index <= idx;
        cfg_if.data  <= data;
        @(posedge i_clk);
        while (!cfg_if.ready) begin
            @(posedge i_clk);
        end
        case (idx)
            tdgr_pkg::CFG_TRIGGER_KEY:    cfg_trigger = data;
            tdgr_pkg::CFG_TARGET_PRESSES: cfg_target  = data[TARGET_W-1:0];
            tdgr_pkg::CFG_HOLD_MODE:      cfg_hold    = data[0];
            tdgr_pkg::CFG_TAP_TIMEOUT:    cfg_tap     = data;
            default: ;
        endcase
    endtask

    task automatic program_gesture(logic [KEY_W-1:0] key, logic [TARGET_W-1:0] target,
                                   logic hold, logic [MS_W-1:0] tap);
        write_reg(tdgr_pkg::CFG_TRIGGER_KEY, key);
        write_reg(tdgr_pkg::CFG_TARGET_PRESSES, CFG_DAT_W'(target));
        write_reg(tdgr_pkg::CFG_HOLD_MODE, CFG_DAT_W'(hold));
        write_reg(tdgr_pkg::CFG_TAP_TIMEOUT, tap);
        cfg_if.valid <= 1'b0;
    endtask

    // One random phase: mostly tap sequences with replay, some noise.
    task automatic play_phase(int n_requests);
        int      goal;
        int      taps;
        int      n_ev;
        int      i;
        t_answer none;
        t_query  q;
        none = '0;
        goal = requests_sent + n_requests;
        while (requests_sent < goal) begin
            if ($urandom_range(99) < 75) begin
                // Long runs push the press count into saturation.
                taps = ($urandom_range(0, 7) == 0) ? $urandom_range(28, 40)
                                                   : $urandom_range(1, 17);
                n_ev = 2 * taps - 1 - $urandom_range(0, 1);
                send_query(trigger_ev(tdgr_pkg::KIND_INITIAL, 1'b1), 1'b0, none);
                for (i = 1; i <= n_ev; i++) begin
                    if ($urandom_range(0, 3) == 0) begin
                        send_query(other_ev(recog_kind()), 1'b0, none);
                    end
                    send_query(trigger_ev(recog_kind(), !i[0]), 1'b0, none);
                end
                if ($urandom_range(0, 9) < 7) begin
                    // Activation replays the same presses.
                    send_query(trigger_ev(tdgr_pkg::KIND_ACT_INITIAL, 1'b1), 1'b0, none);
                    for (i = 1; i <= n_ev; i++) begin
                        if ($urandom_range(0, 5) == 0) begin
                            send_query(other_ev(tdgr_pkg::KIND_ACT_REPLAY), 1'b0, none);
                        end
                        send_query(trigger_ev(tdgr_pkg::KIND_ACT_REPLAY, !i[0]), 1'b0, none);
                    end
                    repeat ($urandom_range(1, 3)) begin
                        if ($urandom_range(0, 1) != 0) begin
                            q = trigger_ev(tdgr_pkg::KIND_ACTIVE, 1'($urandom_range(0, 1)));
                        end else begin
                            q = other_ev(tdgr_pkg::KIND_ACTIVE);
                        end
                        send_query(q, 1'b0, none);
                    end
                end
            end else begin
                q = other_ev(KIND_W'($urandom_range(0, 7)));
                if ($urandom_range(0, 1) != 0) begin
                    q.is_key = 1'b1;
                    q.key    = cfg_trigger;
                end
                send_query(q, 1'b0, none);
            end
        end
    endtask

    task automatic note_error(string what, t_answer want, t_answer got);
        errors++;
        if (errors <= REPORT_MAX) begin
            $display("%s: expected timeout %0d never %0b outcome %0b, got %0d %0b %0b",
                     what, want.timeout, want.never, want.outcome,
                     got.timeout, got.never, got.outcome);
        end
    endtask

    // Result side: random stalls, one long hold-off, and the answer check.
    initial begin
        int      hold_left;
        bit      pressure_done;
        t_answer want;
        t_answer got;
        hold_left     = 0;
        pressure_done = 1'b0;
        out_if.ready <= 1'b0;
        forever begin
            @(posedge i_clk);
            if (i_rst_n && out_if.valid && out_if.ready) begin
                got.timeout = out_if.timeout_ms;
                got.never   = out_if.timeout_never;
                got.outcome = out_if.outcome;
                if (answers_due.size() == 0) begin
                    note_error("answer with no request pending", '0, got);
                end else begin
                    want = answers_due.pop_front();
                    if (got.timeout !== want.timeout || got.never !== want.never ||
                        got.outcome !== want.outcome) begin
                        note_error("answer mismatch", want, got);
                    end
                end
            end
            if (phase_no == PRESSURE_PHASE && !pressure_done) begin
                pressure_done = 1'b1;
                hold_left     = PRESSURE_CYCLES;
            end
            if (hold_left > 0) begin
                hold_left--;
                out_if.ready <= 1'b0;
            end else begin
                out_if.ready <= (phase_no == CALM_PHASE) || ($urandom_range(99) >= IDLE_PCT);
            end
        end
    end

    // Watchdog on the whole run.
    initial begin
        int cycles;
        cycles = 0;
        while (cycles < CYCLE_LIMIT) begin
            @(posedge i_clk);
            cycles++;
        end
        $display("FAIL tap_dance_gesture_resolver_core");
        $finish;
    end

    // Main sequence: reset, directed table, random phases, final drain.
    initial begin
        int p;
        errors        = 0;
        requests_sent = 0;
        cfg_trigger   = tdgr_pkg::TRIGGER_KEY_RST;
        cfg_target    = tdgr_pkg::TARGET_PRESSES_RST;
        cfg_hold      = tdgr_pkg::HOLD_MODE_RST;
        cfg_tap       = tdgr_pkg::TAP_TIMEOUT_RST;
        presses       = 0;
        key_held      = 1'b0;
        phase_no     <= -1;
        i_rst_n      <= 1'b0;
        in_if.valid        <= 1'b0;
        in_if.kind         <= tdgr_pkg::KIND_INITIAL;
        in_if.is_key_event <= 1'b0;
        in_if.event_key    <= '0;
        in_if.pressed      <= 1'b0;
        in_if.ms_left      <= '0;
        cfg_if.valid <= 1'b0;
        cfg_if.index <= tdgr_pkg::CFG_TRIGGER_KEY;
        cfg_if.data  <= '0;

        directed_rows = '{
            // Stray key in an initial request opens nothing.
            dr(tdgr_pkg::KIND_INITIAL,     '1, STRAY_KEY, '1, 16'd0,    '1, 16'd0,   '0, '0),
            // First trigger press starts the tap timer.
            dr(tdgr_pkg::KIND_INITIAL,     '1, TRIG_RST,  '1, 16'hFFFF, '1, TAP_RST, '0, '0),
            dr(tdgr_pkg::KIND_PARTIAL,     '1, TRIG_RST,  '0, 16'd7,    '0, 16'd0,   '0, '0),
            dr(tdgr_pkg::KIND_PARTIAL,     '1, TRIG_RST,  '1, 16'd0,    '0, 16'd0,   '0, '0),
            dr(tdgr_pkg::KIND_COMPLETE,    '1, TRIG_RST,  '0, 16'd0,    '0, 16'd0,   '0, '0),
            // Stray key with no time left resolves with the tap-mode outcome.
            dr(tdgr_pkg::KIND_PARTIAL,     '1, 16'hFFFF,  '1, 16'd0,    '1, 16'd0,   '0, '0),
            dr(tdgr_pkg::KIND_PARTIAL,     '1, 16'hFFFF,  '0, 16'hFFFF, '0, 16'd0,   '0, '0),
            // Not a key event, so the trigger code alone is not a trigger.
            dr(tdgr_pkg::KIND_COMPLETE,    '0, TRIG_RST,  '1, 16'd1,    '0, 16'd0,   '0, '0),
            // One press past the target.
            dr(tdgr_pkg::KIND_PARTIAL,     '1, TRIG_RST,  '1, 16'h8000, '0, 16'd0,   '0, '0),
            dr(tdgr_pkg::KIND_ACT_INITIAL, '1, STRAY_KEY, '1, 16'd0,    '1, 16'd0,   '1, '0),
            dr(tdgr_pkg::KIND_ACT_INITIAL, '1, TRIG_RST,  '1, 16'd0,    '1, 16'd0,   '1, '1),
            dr(tdgr_pkg::KIND_ACT_REPLAY,  '1, TRIG_RST,  '1, 16'd0,    '0, 16'd0,   '0, '0),
            dr(tdgr_pkg::KIND_ACT_REPLAY,  '1, TRIG_RST,  '0, 16'd0,    '0, 16'd0,   '0, '0),
            dr(tdgr_pkg::KIND_ACT_REPLAY,  '1, STRAY_KEY, '0, 16'd3,    '1, 16'd0,   '1, '0),
            // Active requests answer nothing in tap mode.
            dr(tdgr_pkg::KIND_ACTIVE,      '1, TRIG_RST,  '0, 16'd0,    '1, 16'd0,   '0, '0),
            // Unused kinds leave the state alone.
            dr(KIND_SPARE_A,               '1, TRIG_RST,  '1, 16'd0,    '1, 16'd0,   '0, '0),
            dr(KIND_SPARE_B,               '0, 16'hFFFF,  '0, 16'hFFFF, '1, 16'd0,   '0, '0),
            // A release cannot open a gesture.
            dr(tdgr_pkg::KIND_INITIAL,     '1, TRIG_RST,  '0, 16'd0,    '1, 16'd0,   '0, '0)
        };

        repeat (RESET_CYCLES) @(posedge i_clk);
        i_rst_n <= 1'b1;

        for (p = 0; p < DIRECTED_ROWS; p++) begin
            send_query(directed_rows[p].q, directed_rows[p].fixed, directed_rows[p].want);
        end

        // Each phase reprograms every register, the extremes first.
        for (p = 0; p < PHASES; p++) begin
            drain_results();
            case (p)
                0: program_gesture(16'hFFFF, 4'd15, 1'b1, 16'd0);
                1: program_gesture(KEY_W'($urandom_range(0, 65535)), 4'd0, 1'b0, 16'hFFFF);
                2: program_gesture(16'd0, 4'd1, 1'b1, MS_W'($urandom_range(0, 65535)));
                default: begin
                    program_gesture(KEY_W'($urandom_range(0, 65535)),
                                    ($urandom_range(0, 5) == 0) ? 4'd0
                                        : TARGET_W'($urandom_range(1, 15)),
                                    1'($urandom_range(0, 1)), MS_W'($urandom_range(0, 65535)));
                end
            endcase
            phase_no <= p;
            play_phase(PHASE_REQUESTS);
        end
        drain_results();

        if (errors == 0 && answers_due.size() == 0) begin
            $display("PASS tap_dance_gesture_resolver_core");
        end else begin
            $display("FAIL tap_dance_gesture_resolver_core");
        end
        $finish;
    end

endmodule

// ----- filelist.f -----
src/tdgr_pkg.sv
src/tdgr_in_if.sv
src/tdgr_out_if.sv
src/tdgr_cfg_if.sv
src/tap_dance_gesture_resolver_core.sv
bench/tb.sv
